// ----- rtl/gdad_pkg.sv -----
package gdad_pkg;

    localparam int OFFSET_BITS_DEFAULT = 30;
    localparam int STAGES = 11;

    localparam int DAY_BITS = 5;
    localparam int MONTH_BITS = 4;
    localparam int YEAR_BITS = 16;
    localparam int RYEAR_BITS = 22;
    localparam int SERIAL_BITS = 31;
    localparam int SUM_BITS = 34;

    localparam longint unsigned DAYS_400Y = 146097;
    localparam longint unsigned DAYS_100Y = 36524;
    localparam longint unsigned DAYS_4Y = 1461;
    localparam longint unsigned DAYS_1Y = 365;

    localparam longint unsigned YEAR_MAX = 4194303;
    localparam longint unsigned LIMIT = YEAR_MAX * DAYS_1Y + YEAR_MAX / 4 - YEAR_MAX / 100
                                        + YEAR_MAX / 400;
    localparam logic [SERIAL_BITS-1:0] N_MAX = SERIAL_BITS'(LIMIT - 1);

    // Reciprocals for exact division by constants: the shift is at least the sum of the
    // dividend and divisor widths, so the rounded-up reciprocal gives the exact quotient.
    localparam int SHIFT_25 = 19;
    localparam int SHIFT_400Y = 49;
    localparam int SHIFT_4Y = 27;
    localparam longint unsigned R25 = ((64'd1 << SHIFT_25) + 64'd24) / 64'd25;
    localparam longint unsigned R400Y = ((64'd1 << SHIFT_400Y) + DAYS_400Y - 1) / DAYS_400Y;
    localparam longint unsigned R4Y = ((64'd1 << SHIFT_4Y) + DAYS_4Y - 1) / DAYS_4Y;

    typedef struct packed {
        logic [STAGES-1:0] load;
        logic [STAGES-1:0] valid;
    } gdad_ctrl_t;

    function automatic logic [8:0] cum_days(input logic [3:0] idx, input logic leap);
        logic [8:0] d;
        case (idx)
            4'd0: d = 9'd0;
            4'd1: d = 9'd31;
            4'd2: d = 9'd59;
            4'd3: d = 9'd90;
            4'd4: d = 9'd120;
            4'd5: d = 9'd151;
            4'd6: d = 9'd181;
            4'd7: d = 9'd212;
            4'd8: d = 9'd243;
            4'd9: d = 9'd273;
            4'd10: d = 9'd304;
            4'd11: d = 9'd334;
            default: d = 9'd0;
        endcase
        if (leap && (idx >= 4'd2) && (idx <= 4'd11))
        begin
            d = d + 9'd1;
        end
        return d;
    endfunction

endpackage

// ----- rtl/gregorian_date_add_days.sv -----
// Gregorian date plus day offset.
// The start channel (start_valid, start_ready) carries one word: a proleptic Gregorian
// date (start_day, start_month, start_year) and offset_days. The result channel
// (result_valid, result_ready) returns the date that lies offset_days later in
// result_day, result_month and result_year. Each start word gives exactly one result word.
// The block is an eleven-stage pipeline, driven straight from the last stage's registers at the
// result port, and a new word is accepted in every cycle while the result side
// takes words, one word per cycle sustained. The depth is set by the chain of constant
// divisions by 146097, 36524, 1461 and 365 and the month search, each with its own stage.
// When the receiver stalls, stages hold their words and bubbles ahead of the stall are
// filled, so start_ready stays high until all eleven stages hold a word.
// Reset clears all stage valid bits; no result is shown until a word has passed through.
// A date past 31 December 4194303 saturates to that date.
module gregorian_date_add_days #(
    parameter int OFFSET_BITS = gdad_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start_valid,
    output logic                                start_ready,
    input  logic [OFFSET_BITS-1:0]              offset_days,
    input  logic [gdad_pkg::DAY_BITS-1:0]       start_day,
    input  logic [gdad_pkg::MONTH_BITS-1:0]     start_month,
    input  logic [gdad_pkg::YEAR_BITS-1:0]      start_year,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic [gdad_pkg::DAY_BITS-1:0]       result_day,
    output logic [gdad_pkg::MONTH_BITS-1:0]     result_month,
    output logic [gdad_pkg::RYEAR_BITS-1:0]     result_year
);

    localparam int SUM_BITS = gdad_pkg::SUM_BITS;
    localparam int SERIAL_BITS = gdad_pkg::SERIAL_BITS;

    gdad_pkg::gdad_ctrl_t ctrl;

    gdad_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start_valid  (start_valid),
        .result_ready (result_ready),
        .ctrl         (ctrl)
    );

    assign start_ready = ctrl.load[0];
    assign result_valid = ctrl.valid[gdad_pkg::STAGES-1];

    // Stage 1 signals.
    logic [4:0]  day_c;
    logic [3:0]  month_c;
    logic [15:0] year_c;
    logic [15:0] p_c;
    logic [28:0] p100_prod;
    logic [28:0] y100_prod;
    logic [24:0] s1_p365_next, s1_p365_reg;
    logic [13:0] s1_p4_reg;
    logic [9:0]  s1_p100_reg;
    logic [13:0] s1_y4_reg;
    logic [9:0]  s1_yq25_reg;
    logic        s1_yz_reg;
    logic [3:0]  s1_month_reg;
    logic [4:0]  s1_day_reg;
    logic [OFFSET_BITS-1:0] s1_off_reg;

    // Stage 2 signals.
    logic [13:0] y25_mul;
    logic        leap_start;
    logic [8:0]  dbm;
    logic [24:0] s2_a_next, s2_a_reg;
    logic [OFFSET_BITS-1:0] s2_off_reg;

    // Stage 3 signals.
    logic [SUM_BITS-1:0]    sum3;
    logic [SERIAL_BITS-1:0] s3_n_next, s3_n_reg;

    // Stage 4 to 11 signals.
    logic [62:0] q400_prod;
    logic [SERIAL_BITS-1:0] s4_n_reg;
    logic [13:0] s4_q400_reg;
    logic [SERIAL_BITS-1:0] r400_full;
    logic [17:0] s5_r400_reg;
    logic [21:0] s5_y400_reg;
    logic [1:0]  s6_q100_next, s6_q100_reg;
    logic [17:0] base100;
    logic [17:0] r100_full;
    logic [15:0] s6_r100_reg;
    logic [21:0] s6_y400_reg;
    logic [31:0] q4_prod;
    logic [4:0]  s7_q4_reg;
    logic [15:0] s7_r100_reg;
    logic [1:0]  s7_q100_reg;
    logic [21:0] s7_y400_reg;
    logic [15:0] r4_full;
    logic [10:0] s8_r4_reg;
    logic [4:0]  s8_q4_reg;
    logic [1:0]  s8_q100_reg;
    logic [21:0] s8_y400_reg;
    logic [1:0]  q1_c;
    logic [10:0] base1;
    logic [10:0] r1_full;
    logic        s9_leap_next, s9_leap_reg;
    logic [21:0] s9_ry_next, s9_ry_reg;
    logic [8:0]  s9_r1_reg;
    logic [3:0]  s10_rm_next, s10_rm_reg;
    logic [8:0]  s10_r1_reg;
    logic        s10_leap_reg;
    logic [21:0] s10_ry_reg;
    logic [8:0]  day_full;
    logic [4:0]  s11_day_reg;
    logic [3:0]  s11_month_reg;
    logic [21:0] s11_year_reg;

    always_comb
    begin
        day_c = (start_day == 5'd0) ? 5'd1 : start_day;
        if (start_month == 4'd0)
        begin
            month_c = 4'd1;
        end
        else if (start_month > 4'd12)
        begin
            month_c = 4'd12;
        end
        else
        begin
            month_c = start_month;
        end
        year_c = (start_year == 16'd0) ? 16'd1 : start_year;
        p_c = year_c - 16'd1;
        s1_p365_next = 25'(p_c) * 25'(gdad_pkg::DAYS_1Y);
        p100_prod = 29'(p_c[15:2]) * 29'(gdad_pkg::R25);
        y100_prod = 29'(year_c[15:2]) * 29'(gdad_pkg::R25);
    end

    always_comb
    begin
        y25_mul = 14'(s1_yq25_reg) * 14'd25;
        leap_start = s1_yz_reg && ((y25_mul != s1_y4_reg) || (s1_yq25_reg[1:0] == 2'd0));
        dbm = gdad_pkg::cum_days(s1_month_reg - 4'd1, leap_start);
        s2_a_next = s1_p365_reg + 25'(s1_p4_reg) - 25'(s1_p100_reg) + 25'(s1_p100_reg[9:2])
                  + 25'(dbm) + 25'(s1_day_reg) - 25'd1;
    end

    always_comb
    begin
        sum3 = SUM_BITS'(s2_a_reg) + SUM_BITS'(s2_off_reg);
        if (sum3 > SUM_BITS'(gdad_pkg::N_MAX))
        begin
            s3_n_next = gdad_pkg::N_MAX;
        end
        else
        begin
            s3_n_next = sum3[SERIAL_BITS-1:0];
        end
    end

    assign q400_prod = 63'(s3_n_reg) * 63'(gdad_pkg::R400Y);
    assign r400_full = s4_n_reg - SERIAL_BITS'(s4_q400_reg) * SERIAL_BITS'(gdad_pkg::DAYS_400Y);

    always_comb
    begin
        if (s5_r400_reg >= 18'(3 * gdad_pkg::DAYS_100Y))
        begin
            s6_q100_next = 2'd3;
        end
        else if (s5_r400_reg >= 18'(2 * gdad_pkg::DAYS_100Y))
        begin
            s6_q100_next = 2'd2;
        end
        else if (s5_r400_reg >= 18'(gdad_pkg::DAYS_100Y))
        begin
            s6_q100_next = 2'd1;
        end
        else
        begin
            s6_q100_next = 2'd0;
        end
        base100 = 18'(s6_q100_next) * 18'(gdad_pkg::DAYS_100Y);
        r100_full = s5_r400_reg - base100;
    end

    assign q4_prod = 32'(s6_r100_reg) * 32'(gdad_pkg::R4Y);
    assign r4_full = s7_r100_reg - 16'(s7_q4_reg) * 16'(gdad_pkg::DAYS_4Y);

    always_comb
    begin
        if (s8_r4_reg >= 11'(3 * gdad_pkg::DAYS_1Y))
        begin
            q1_c = 2'd3;
        end
        else if (s8_r4_reg >= 11'(2 * gdad_pkg::DAYS_1Y))
        begin
            q1_c = 2'd2;
        end
        else if (s8_r4_reg >= 11'(gdad_pkg::DAYS_1Y))
        begin
            q1_c = 2'd1;
        end
        else
        begin
            q1_c = 2'd0;
        end
        base1 = 11'(q1_c) * 11'(gdad_pkg::DAYS_1Y);
        r1_full = s8_r4_reg - base1;
        s9_leap_next = (q1_c == 2'd3) && ((s8_q4_reg != 5'd24) || (s8_q100_reg == 2'd3));
        s9_ry_next = s8_y400_reg + 22'(s8_q100_reg) * 22'd100 + {15'd0, s8_q4_reg, 2'b00}
                   + 22'(q1_c) + 22'd1;
    end

    always_comb
    begin
        s10_rm_next = 4'd0;
        for (int i = 1; i < 12; i++)
        begin
            s10_rm_next = s10_rm_next
                        + 4'(s9_r1_reg >= gdad_pkg::cum_days(4'(i), s9_leap_reg));
        end
    end

    assign day_full = s10_r1_reg - gdad_pkg::cum_days(s10_rm_reg, s10_leap_reg) + 9'd1;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            s1_p365_reg <= s1_p365_next;
            s1_p4_reg <= p_c[15:2];
            s1_p100_reg <= p100_prod[28:gdad_pkg::SHIFT_25];
            s1_y4_reg <= year_c[15:2];
            s1_yq25_reg <= y100_prod[28:gdad_pkg::SHIFT_25];
            s1_yz_reg <= (year_c[1:0] == 2'd0);
            s1_month_reg <= month_c;
            s1_day_reg <= day_c;
            s1_off_reg <= offset_days;
        end
        if (ctrl.load[1])
        begin
            s2_a_reg <= s2_a_next;
            s2_off_reg <= s1_off_reg;
        end
        if (ctrl.load[2])
        begin
            s3_n_reg <= s3_n_next;
        end
        if (ctrl.load[3])
        begin
            s4_n_reg <= s3_n_reg;
            s4_q400_reg <= q400_prod[gdad_pkg::SHIFT_400Y+13:gdad_pkg::SHIFT_400Y];
        end
        if (ctrl.load[4])
        begin
            s5_r400_reg <= r400_full[17:0];
            s5_y400_reg <= 22'(s4_q400_reg) * 22'd400;
        end
        if (ctrl.load[5])
        begin
            s6_q100_reg <= s6_q100_next;
            s6_r100_reg <= r100_full[15:0];
            s6_y400_reg <= s5_y400_reg;
        end
        if (ctrl.load[6])
        begin
            s7_q4_reg <= q4_prod[gdad_pkg::SHIFT_4Y+4:gdad_pkg::SHIFT_4Y];
            s7_r100_reg <= s6_r100_reg;
            s7_q100_reg <= s6_q100_reg;
            s7_y400_reg <= s6_y400_reg;
        end
        if (ctrl.load[7])
        begin
            s8_r4_reg <= r4_full[10:0];
            s8_q4_reg <= s7_q4_reg;
            s8_q100_reg <= s7_q100_reg;
            s8_y400_reg <= s7_y400_reg;
        end
        if (ctrl.load[8])
        begin
            s9_r1_reg <= r1_full[8:0];
            s9_leap_reg <= s9_leap_next;
            s9_ry_reg <= s9_ry_next;
        end
        if (ctrl.load[9])
        begin
            s10_rm_reg <= s10_rm_next;
            s10_r1_reg <= s9_r1_reg;
            s10_leap_reg <= s9_leap_reg;
            s10_ry_reg <= s9_ry_reg;
        end
        if (ctrl.load[10])
        begin
            s11_day_reg <= day_full[4:0];
            s11_month_reg <= s10_rm_reg + 4'd1;
            s11_year_reg <= s10_ry_reg;
        end
    end

    assign result_day = s11_day_reg;
    assign result_month = s11_month_reg;
    assign result_year = s11_year_reg;

endmodule

// ----- rtl/gdad_ctrl.sv -----
module gdad_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start_valid,
    input  logic                result_ready,
    output gdad_pkg::gdad_ctrl_t ctrl
);

    localparam int STAGES = gdad_pkg::STAGES;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] load;

    // A stage may load when the output is taken or any stage from it onward holds a bubble.
    always_comb
    begin
        for (int i = 0; i < STAGES; i++)
        begin
            load[i] = result_ready
                   || ((valid_reg | ((STAGES'(1) << i) - STAGES'(1))) != {STAGES{1'b1}});
        end
        valid_next[0] = load[0] ? start_valid : valid_reg[0];
        for (int i = 1; i < STAGES; i++)
        begin
            valid_next[i] = load[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctrl.load = load;
    assign ctrl.valid = valid_reg;

    a_word_count: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> ($countones(valid_reg) == $past($countones(valid_reg))
            + int'($past(start_valid && load[0]))
            - int'($past(result_ready && valid_reg[STAGES-1]))))
        else $error("pipeline word count does not match accepted and delivered words");

    a_full_refuses: assert property (@(posedge clk) disable iff (!rst_n)
        ((&valid_reg) && !result_ready) |-> !load[0])
        else $error("full stalled pipeline accepts a word");

    a_ready_moves_all: assert property (@(posedge clk) disable iff (!rst_n)
        result_ready |-> (&load))
        else $error("taken output does not advance every stage");

endmodule
